>>> sv/dbps_pkg.sv
// Shared types and constants for the dE/dx band particle selector.
package dbps_pkg;

  localparam int CNT_W      = 32;
  localparam int NUM_REGS   = 8;
  localparam int REG_W      = 24;
  localparam int SQRT_STEPS = 26;
  localparam int LOG_STEPS  = 24;
  localparam int DIV_STEPS  = 40;
  localparam int TERM_PHASES = 3;

  localparam logic [31:0] LN2_Q30    = 32'd744261118;
  localparam logic [47:0] RECIP_CAP  = 48'hFF_FFFF_FFFF;
  localparam logic signed [25:0] LNP_MIN = -26'sd786432;
  localparam logic signed [25:0] LNP_MAX = 26'sd393216;
  localparam logic signed [21:0] X_OFFSET = 22'sd131072;

  localparam logic [REG_W-1:0] COEF_RESET [NUM_REGS] = '{
    24'd203459, 24'hFA7EC6, 24'd254373, 24'hFF85A4,
    24'd22808,  24'hFEA794, 24'd105726, 24'hFF79A3
  };

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ,
    OP_SQRT_INIT_P,
    OP_SQRT_INIT_X,
    OP_SQRT_STEP,
    OP_LOG_INIT,
    OP_LOG_STEP,
    OP_LOG_MUL,
    OP_LOG_FIN,
    OP_DIV_INIT_ROOT,
    OP_DIV_INIT_INV,
    OP_DIV_STEP,
    OP_SAVE_ROOT,
    OP_SAVE_INV,
    OP_RSQ,
    OP_RSQ_SAVE,
    OP_CURVE_INIT,
    OP_TERM_LO,
    OP_TERM_HI,
    OP_TERM_ADD,
    OP_BAND,
    OP_OUT
  } dbps_op_t;

  typedef struct packed {
    dbps_op_t    op;
    logic [1:0]  sel;
    logic        curve;
  } dbps_cmd_t;

  typedef struct packed {
    logic go_eval;
    logic out_free;
  } dbps_sts_t;

endpackage

>>> sv/dbps_ctrl.sv
// Sequencer that steps the shared datapath through one track.
module dbps_ctrl import dbps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  dbps_sts_t sts,
  output dbps_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_SQ, S_SQRT_P, S_SQRT, S_LOG_INIT, S_LOG, S_LOG_MUL, S_LOG_FIN,
    S_CHECK, S_DIV_R_INIT, S_DIV, S_SAVE_R, S_DIV_I_INIT, S_SAVE_I, S_RSQ,
    S_RSQ_SAVE, S_CURVE_INIT, S_TERM, S_BAND, S_DONE
  } state_t;

  state_t      state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        phase_r, phase_nxt;
  logic [1:0]  term_r, term_nxt;
  logic        curve_r, curve_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    phase_nxt = phase_r;
    term_nxt  = term_r;
    curve_nxt = curve_r;
    cmd.op    = OP_NONE;
    cmd.sel   = cnt_r[1:0];
    cmd.curve = curve_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          cnt_nxt   = '0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.op = OP_SQ;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd2) state_nxt = S_SQRT_P;
      end
      S_SQRT_P: begin
        cmd.op    = OP_SQRT_INIT_P;
        cnt_nxt   = '0;
        phase_nxt = 1'b0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op  = OP_SQRT_STEP;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(SQRT_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = phase_r ? S_DIV_R_INIT : S_LOG_INIT;
        end
      end
      S_LOG_INIT: begin
        cmd.op    = OP_LOG_INIT;
        cnt_nxt   = '0;
        state_nxt = S_LOG;
      end
      S_LOG: begin
        cmd.op  = OP_LOG_STEP;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(LOG_STEPS - 1)) state_nxt = S_LOG_MUL;
      end
      S_LOG_MUL: begin
        cmd.op    = OP_LOG_MUL;
        state_nxt = S_LOG_FIN;
      end
      S_LOG_FIN: begin
        cmd.op    = OP_LOG_FIN;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        // skip the curves for tracks that cannot pass
        cmd.op    = OP_SQRT_INIT_X;
        cnt_nxt   = '0;
        phase_nxt = 1'b1;
        state_nxt = sts.go_eval ? S_SQRT : S_DONE;
      end
      S_DIV_R_INIT: begin
        cmd.op    = OP_DIV_INIT_ROOT;
        cnt_nxt   = '0;
        phase_nxt = 1'b0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op  = OP_DIV_STEP;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = phase_r ? S_SAVE_I : S_SAVE_R;
        end
      end
      S_SAVE_R: begin
        cmd.op    = OP_SAVE_ROOT;
        state_nxt = S_DIV_I_INIT;
      end
      S_DIV_I_INIT: begin
        cmd.op    = OP_DIV_INIT_INV;
        cnt_nxt   = '0;
        phase_nxt = 1'b1;
        state_nxt = S_DIV;
      end
      S_SAVE_I: begin
        cmd.op    = OP_SAVE_INV;
        cnt_nxt   = '0;
        state_nxt = S_RSQ;
      end
      S_RSQ: begin
        cmd.op  = OP_RSQ;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd2) state_nxt = S_RSQ_SAVE;
      end
      S_RSQ_SAVE: begin
        cmd.op    = OP_RSQ_SAVE;
        state_nxt = S_CURVE_INIT;
      end
      S_CURVE_INIT: begin
        cmd.op    = OP_CURVE_INIT;
        cnt_nxt   = '0;
        term_nxt  = 2'd1;
        curve_nxt = 1'b0;
        state_nxt = S_TERM;
      end
      S_TERM: begin
        cmd.sel = term_r;
        cnt_nxt = cnt_r + 6'd1;
        priority if (cnt_r == 6'd0) begin
          cmd.op = OP_TERM_LO;
        end else if (cnt_r == 6'd1) begin
          cmd.op = OP_TERM_HI;
        end else begin
          cmd.op  = OP_TERM_ADD;
          cnt_nxt = '0;
          if (term_r == 2'd3) begin
            term_nxt = 2'd1;
            if (curve_r) state_nxt = S_BAND;
            else curve_nxt = 1'b1;
          end else begin
            term_nxt = term_r + 2'd1;
          end
        end
      end
      S_BAND: begin
        cmd.op    = OP_BAND;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      phase_r <= 1'b0;
      term_r  <= 2'd1;
      curve_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      phase_r <= phase_nxt;
      term_r  <= term_nxt;
      curve_r <= curve_nxt;
    end
  end

`ifndef SYNTH
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_OUT) |-> sts.out_free) else $error("result written while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && sts.out_free) |=> (state_r == S_IDLE))
    else $error("finished track not released");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < 6'(DIV_STEPS)) else $error("step counter overrun");
  a_term_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TERM) |-> (term_r != 2'd0)) else $error("bad curve term");
`endif

endmodule

>>> sv/dbps_dp.sv
// Datapath: shared multiplier, square root, logarithm and divider steps, band compare.
module dbps_dp import dbps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  dbps_cmd_t   cmd,
  output dbps_sts_t   sts,
  input  logic [95:0] in_tdata,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata
);

  logic [REG_W-1:0] coef_r [NUM_REGS];

  logic [2:0]  chg_r;
  logic [23:0] ax_r, ay_r, az_r;
  logic [15:0] eloss_r;
  logic [79:0] acc_r;
  logic [51:0] rad_r;
  logic [25:0] root_r;
  logic [27:0] srem_r;
  logic [23:0] p_r;
  logic [4:0]  k_r;
  logic        pzero_r;
  logic [30:0] m_r;
  logic [23:0] frac_r;
  logic        lneg_r;
  logic signed [20:0] lnp_r;
  logic [19:0] x_r;
  logic        go_r;
  logic [25:0] dd_r;
  logic [26:0] drem_r;
  logic [39:0] q_r;
  logic        sat_r;
  logic [47:0] rroot_r, rinv_r, rsq_r;
  logic signed [43:0] mean_r, sig_r;
  logic        sel_r;

  logic        ovalid_r;
  logic [23:0] o_p_r;
  logic [20:0] o_lnp_r;
  logic        o_neg_r, o_sel_r;
  logic [CNT_W-1:0] total_r;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [23:0] cur_coef, cmag;
  logic [47:0] rsel;
  logic [4:0]  k_c;
  logic signed [29:0] l2;
  logic [29:0] l2mag;
  logic        neg;
  logic [29:0] s_r, s_trial;
  logic [26:0] d_r2;
  logic [31:0] mn;
  logic signed [63:0] lprod, lrnd;
  logic signed [25:0] ln26, lncl;
  logic signed [21:0] xs;
  logic [47:0] tmag;
  logic signed [43:0] tval;
  logic signed [45:0] lob, hib, e4;
  logic [CNT_W-1:0] total_nxt;

  assign neg = (chg_r == 3'b111);

  always_comb begin
    cur_coef = coef_r[{cmd.curve, cmd.sel}];
    cmag     = cur_coef[23] ? (24'd0 - cur_coef) : cur_coef;
    unique case (cmd.sel)
      2'd1:    rsel = rroot_r;
      2'd2:    rsel = rinv_r;
      default: rsel = rsq_r;
    endcase
  end

  always_comb begin
    k_c = '0;
    for (int i = 0; i < 24; i++) begin
      if (root_r[i]) k_c = 5'(i);
    end
  end

  assign l2    = signed'({6'({1'b0, k_r} - 6'd16), frac_r});
  assign l2mag = l2[29] ? (30'd0 - l2) : l2;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_SQ: begin
        unique case (cmd.sel)
          2'd0:    mul_a = 32'(ax_r);
          2'd1:    mul_a = 32'(ay_r);
          default: mul_a = 32'(az_r);
        endcase
        mul_b = mul_a;
      end
      OP_LOG_STEP: begin
        mul_a = 32'(m_r);
        mul_b = 32'(m_r);
      end
      OP_LOG_MUL: begin
        mul_a = 32'(l2mag);
        mul_b = LN2_Q30;
      end
      OP_RSQ: begin
        mul_a = (cmd.sel == 2'd0) ? 32'(rinv_r[19:0]) : 32'(rinv_r[39:20]);
        mul_b = (cmd.sel == 2'd2) ? 32'(rinv_r[39:20]) : 32'(rinv_r[19:0]);
      end
      OP_TERM_LO: begin
        mul_a = 32'(cmag);
        mul_b = 32'(rsel[23:0]);
      end
      OP_TERM_HI: begin
        mul_a = 32'(cmag);
        mul_b = 32'(rsel[47:24]);
      end
      default: ;
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);

  // one digit of the square root per step
  assign s_r     = {srem_r, rad_r[51:50]};
  assign s_trial = {2'b00, root_r, 2'b01};
  assign d_r2    = {drem_r[25:0], 1'b0};
  assign mn      = prod[61:30];

  always_comb begin
    lprod = lneg_r ? (64'sd0 - signed'(acc_r[63:0])) : signed'(acc_r[63:0]);
    lrnd  = (lprod + (64'sd1 <<< 37)) >>> 38;
    ln26  = lrnd[25:0];
    priority if (pzero_r || ln26 < LNP_MIN) lncl = LNP_MIN;
    else if (ln26 > LNP_MAX) lncl = LNP_MAX;
    else lncl = ln26;
    xs = 22'(lncl) + X_OFFSET;
  end

  assign tmag = acc_r[79:32];
  assign tval = cur_coef[23] ? (44'sd0 - signed'(44'(tmag))) : signed'(44'(tmag));

  assign lob = 46'(mean_r) - (46'(sig_r) <<< 1);
  assign hib = 46'(mean_r) + 46'(sig_r) + (46'(sig_r) <<< 1);
  assign e4  = signed'(46'({eloss_r, 4'b0000}));

  assign total_nxt = (sel_r && total_r != {CNT_W{1'b1}}) ? total_r + 1'b1 : total_r;

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        chg_r   <= in_tdata[2:0];
        ax_r    <= in_tdata[26]  ? 24'd0 - in_tdata[26:3]  : in_tdata[26:3];
        ay_r    <= in_tdata[50]  ? 24'd0 - in_tdata[50:27] : in_tdata[50:27];
        az_r    <= in_tdata[74]  ? 24'd0 - in_tdata[74:51] : in_tdata[74:51];
        eloss_r <= in_tdata[90:75];
        acc_r   <= '0;
      end
      OP_SQ: acc_r <= acc_r + 80'(prod);
      OP_SQRT_INIT_P: begin
        rad_r  <= acc_r[51:0];
        root_r <= '0;
        srem_r <= '0;
      end
      OP_SQRT_INIT_X: begin
        rad_r  <= {x_r, 32'd0};
        root_r <= '0;
        srem_r <= '0;
      end
      OP_SQRT_STEP: begin
        rad_r <= {rad_r[49:0], 2'b00};
        if (s_r >= s_trial) begin
          srem_r <= 28'(s_r - s_trial);
          root_r <= {root_r[24:0], 1'b1};
        end else begin
          srem_r <= s_r[27:0];
          root_r <= {root_r[24:0], 1'b0};
        end
      end
      OP_LOG_INIT: begin
        p_r     <= root_r[23:0];
        k_r     <= k_c;
        pzero_r <= (root_r[23:0] == 24'd0);
        m_r     <= 31'(root_r[23:0]) << (5'd30 - k_c);
        frac_r  <= '0;
      end
      OP_LOG_STEP: begin
        if (mn[31]) m_r <= mn[31:1];
        else m_r <= mn[30:0];
        frac_r <= {frac_r[22:0], mn[31]};
      end
      OP_LOG_MUL: begin
        acc_r  <= 80'(prod);
        lneg_r <= l2[29];
      end
      OP_LOG_FIN: begin
        lnp_r <= lncl[20:0];
        x_r   <= xs[19:0];
        go_r  <= neg && (xs > 22'sd0);
      end
      OP_DIV_INIT_ROOT: begin
        dd_r   <= root_r;
        drem_r <= 27'd65536;
        sat_r  <= (root_r <= 26'd65536);
        q_r    <= '0;
      end
      OP_DIV_INIT_INV: begin
        dd_r   <= 26'(x_r);
        drem_r <= 27'd256;
        sat_r  <= (x_r <= 20'd256);
        q_r    <= '0;
      end
      OP_DIV_STEP: begin
        if (d_r2 >= {1'b0, dd_r}) begin
          drem_r <= d_r2 - {1'b0, dd_r};
          q_r    <= {q_r[38:0], 1'b1};
        end else begin
          drem_r <= d_r2;
          q_r    <= {q_r[38:0], 1'b0};
        end
      end
      OP_SAVE_ROOT: rroot_r <= sat_r ? RECIP_CAP : 48'(q_r);
      OP_SAVE_INV:  rinv_r  <= sat_r ? RECIP_CAP : 48'(q_r);
      OP_RSQ: begin
        unique case (cmd.sel)
          2'd0:    acc_r <= 80'(prod);
          2'd1:    acc_r <= acc_r + (80'(prod) << 21);
          default: acc_r <= acc_r + (80'(prod) << 40);
        endcase
      end
      OP_RSQ_SAVE: rsq_r <= acc_r[79:32];
      OP_CURVE_INIT: begin
        mean_r <= 44'(signed'(coef_r[0]));
        sig_r  <= 44'(signed'(coef_r[4]));
      end
      OP_TERM_LO: acc_r <= 80'(prod);
      OP_TERM_HI: acc_r <= acc_r + (80'(prod) << 24);
      OP_TERM_ADD: begin
        if (cmd.curve) sig_r <= sig_r + tval;
        else mean_r <= mean_r + tval;
      end
      OP_BAND: sel_r <= (e4 > lob) && (e4 < hib);
      OP_OUT: begin
        o_p_r   <= p_r;
        o_lnp_r <= lnp_r;
        o_neg_r <= neg;
        o_sel_r <= sel_r;
      end
      default: ;
    endcase
    if (cmd.op == OP_LOAD) sel_r <= 1'b0;
  end

  // control: configuration, result handshake, running count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) coef_r[i] <= COEF_RESET[i];
      ovalid_r <= 1'b0;
      total_r  <= '0;
    end else begin
      if (cfg_valid) coef_r[cfg_index] <= cfg_data;
      if (cmd.op == OP_OUT) begin
        ovalid_r <= 1'b1;
        total_r  <= total_nxt;
      end else if (out_tready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  assign sts.go_eval  = go_r;
  assign sts.out_free = !ovalid_r || out_tready;

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {1'b0, total_r[31:0], o_sel_r, o_neg_r, o_lnp_r, o_p_r};

`ifndef SYNTH
  a_sel_neg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && o_sel_r) |-> o_neg_r) else $error("selected track not negative");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_OUT) |=> (total_r == $past(total_nxt)))
    else $error("count not updated");
  a_lnp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_OUT) |-> (lnp_r >= 21'(LNP_MIN) && lnp_r <= 21'(LNP_MAX)))
    else $error("log out of range");
`endif

endmodule

>>> sv/dedx_band_particle_select.sv
// Top level of the dE/dx band particle selector.
//
//  channel | direction | handshake              | payload
//  in_     | in        | in_tvalid / in_tready   | in_tdata: track
//  out_    | out       | out_tvalid / out_tready | out_tdata: result
//  cfg_    | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One track at a time, through the shared bit-serial square root (26 steps), log
// squaring (24 steps) and divider (2 x 40 steps); the second square root, the
// divider and the curves run only for a negative track with ln p > -2.
// Reset (rst_n low, synchronous) loads the coefficient defaults and clears
// the count. A new request is taken while a finished result waits on out_.
module dedx_band_particle_select import dbps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] track_charge, [26:3] mom_x, [50:27] mom_y, [74:51] mom_z,
  // [90:75] energy_loss
  input  logic [95:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [23:0] mom_magnitude, [44:24] log_mom, [45] is_negative, [46] selected,
  // [78:47] selected_total
  output logic [79:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  dbps_cmd_t cmd;
  dbps_sts_t sts;

  assign cfg_ready = 1'b1;

  dbps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dbps_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
